// ===== rtl/core/sspi_pkg.sv =====
// ----------------------------------------------------------------------------
// Clocked synchronous serial master package
// Item codes, register selects, status bit positions and the result type.
// ----------------------------------------------------------------------------
package sspi_pkg;

    // Item kinds.
    localparam logic [1:0] FUNC_READ   = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Bus register selects.
    localparam logic [1:0] REG_CTRL   = 2'd0;
    localparam logic [1:0] REG_TXDATA = 2'd1;
    localparam logic [1:0] REG_STATUS = 2'd2;
    localparam logic [1:0] REG_RXDATA = 2'd3;

    // Control register bit positions.
    localparam int unsigned CTRL_TXE_BIT = 5;
    localparam int unsigned CTRL_RXE_BIT = 4;

    // Status register bit positions.
    localparam int unsigned STAT_TXEMPTY_BIT = 7;
    localparam int unsigned STAT_RXFULL_BIT  = 6;
    localparam int unsigned STAT_OVERRUN_BIT = 5;
    localparam int unsigned STAT_TXEND_BIT   = 2;

    // Configuration register indexes.
    localparam logic CFG_MSB_FIRST = 1'b0;

    localparam logic [7:0] SHIFT_IDLE = 8'hFF;

    typedef struct packed {
        logic [7:0] rdata;
        logic       mosi_bit;
        logic       clocked;
        logic       busy_res;
    } t_result;

endpackage

// ===== rtl/core/sspi_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Command channel
// Carries one bus access or serial bit tick per item.
// ----------------------------------------------------------------------------
interface sspi_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [1:0] reg_sel;
    logic [7:0] wdata;
    logic       miso_bit;

    modport source (output valid, output func, output reg_sel, output wdata,
                    output miso_bit, input ready);
    modport sink (input valid, input func, input reg_sel, input wdata,
                  input miso_bit, output ready);
endinterface

// ===== rtl/core/sspi_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Carries one result item for every command item.
// ----------------------------------------------------------------------------
interface sspi_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] rdata;
    logic       mosi_bit;
    logic       clocked;
    logic       busy_res;

    modport source (output valid, output rdata, output mosi_bit, output clocked,
                    output busy_res, input ready);
    modport sink (input valid, input rdata, input mosi_bit, input clocked,
                  input busy_res, output ready);
endinterface

// ===== rtl/core/sspi_apb.sv =====
// ----------------------------------------------------------------------------
// Configuration register port
// APB-style slave that holds the bit order setting.
// ----------------------------------------------------------------------------
module sspi_apb (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        o_msb_first
);
    import sspi_pkg::*;

    logic r_msb_first;
    logic n_msb_first;
    logic hit;

    assign hit    = (paddr[2] == CFG_MSB_FIRST);
    assign pready = 1'b1;

    always_comb begin
        n_msb_first = r_msb_first;
        if (psel && penable && pwrite && hit) begin
            n_msb_first = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msb_first <= 1'b0;
        end else begin
            r_msb_first <= n_msb_first;
        end
    end

    assign prdata      = hit ? {31'd0, r_msb_first} : 32'd0;
    assign o_msb_first = r_msb_first;
endmodule

// ===== rtl/core/sspi_core.sv =====
// ----------------------------------------------------------------------------
// Serial master register and shift core
// Holds the bus registers, flags and shifters and works out one item.
// ----------------------------------------------------------------------------
module sspi_core #(
    parameter int FRAME_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [1:0]        i_func,
    input  logic [1:0]        i_reg_sel,
    input  logic [7:0]        i_wdata,
    input  logic              i_miso_bit,
    input  logic              i_msb_first,
    output sspi_pkg::t_result o_result
);
    import sspi_pkg::*;

    localparam int CNT_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BITS - 1);

    logic             r_tx_enable,  n_tx_enable;
    logic             r_rx_enable,  n_rx_enable;
    logic [7:0]       r_tx_hold,    n_tx_hold;
    logic [7:0]       r_tx_shift,   n_tx_shift;
    logic [7:0]       r_rx_shift,   n_rx_shift;
    logic [7:0]       r_rx_hold,    n_rx_hold;
    logic [CNT_W-1:0] r_bit_count,  n_bit_count;
    logic             r_tx_empty,   n_tx_empty;
    logic             r_rx_full,    n_rx_full;
    logic             r_overrun,    n_overrun;
    logic             r_tx_end,     n_tx_end;
    logic             r_shifting,   n_shifting;

    always_comb begin
        n_tx_enable = r_tx_enable;
        n_rx_enable = r_rx_enable;
        n_tx_hold   = r_tx_hold;
        n_tx_shift  = r_tx_shift;
        n_rx_shift  = r_rx_shift;
        n_rx_hold   = r_rx_hold;
        n_bit_count = r_bit_count;
        n_tx_empty  = r_tx_empty;
        n_rx_full   = r_rx_full;
        n_overrun   = r_overrun;
        n_tx_end    = r_tx_end;
        n_shifting  = r_shifting;

        o_result.rdata    = 8'd0;
        o_result.mosi_bit = 1'b1;
        o_result.clocked  = 1'b0;

        if (i_step) begin
            case (i_func)
                FUNC_READ: begin
                    case (i_reg_sel)
                        REG_CTRL: begin
                            o_result.rdata[CTRL_TXE_BIT] = r_tx_enable;
                            o_result.rdata[CTRL_RXE_BIT] = r_rx_enable;
                        end
                        REG_TXDATA: o_result.rdata = r_tx_hold;
                        REG_STATUS: begin
                            o_result.rdata[STAT_TXEMPTY_BIT] = r_tx_empty;
                            o_result.rdata[STAT_RXFULL_BIT]  = r_rx_full;
                            o_result.rdata[STAT_OVERRUN_BIT] = r_overrun;
                            o_result.rdata[STAT_TXEND_BIT]   = r_tx_end;
                        end
                        default: o_result.rdata = r_rx_hold;
                    endcase
                end
                FUNC_WRITE: begin
                    case (i_reg_sel)
                        REG_CTRL: begin
                            n_tx_enable = i_wdata[CTRL_TXE_BIT];
                            n_rx_enable = i_wdata[CTRL_RXE_BIT];
                            // Turning transmit off aborts the frame in flight.
                            if (!i_wdata[CTRL_TXE_BIT]) begin
                                n_shifting  = 1'b0;
                                n_bit_count = '0;
                                n_tx_shift  = SHIFT_IDLE;
                                n_tx_empty  = 1'b1;
                                n_tx_end    = 1'b1;
                            end
                        end
                        REG_TXDATA: n_tx_hold = i_wdata;
                        REG_STATUS: begin
                            if (!i_wdata[STAT_TXEMPTY_BIT]) n_tx_empty = 1'b0;
                            if (!i_wdata[STAT_RXFULL_BIT])  n_rx_full  = 1'b0;
                            if (!i_wdata[STAT_OVERRUN_BIT]) n_overrun  = 1'b0;
                        end
                        default: ;
                    endcase
                    // Any write may make a queued byte startable.
                    if (n_tx_enable && !n_shifting && !n_tx_empty) begin
                        n_tx_shift  = n_tx_hold;
                        n_tx_empty  = 1'b1;
                        n_tx_end    = 1'b0;
                        n_bit_count = '0;
                        n_shifting  = 1'b1;
                    end
                end
                FUNC_TICK: begin
                    if (r_shifting) begin
                        o_result.clocked = 1'b1;
                        if (i_msb_first) begin
                            o_result.mosi_bit = r_tx_shift[7];
                            n_tx_shift = {r_tx_shift[6:0], 1'b1};
                            if (r_rx_enable) n_rx_shift = {r_rx_shift[6:0], i_miso_bit};
                        end else begin
                            o_result.mosi_bit = r_tx_shift[0];
                            n_tx_shift = {1'b1, r_tx_shift[7:1]};
                            if (r_rx_enable) n_rx_shift = {i_miso_bit, r_rx_shift[7:1]};
                        end
                        if (r_bit_count == CNT_LAST) begin
                            n_bit_count = '0;
                            if (r_rx_enable) begin
                                if (r_rx_full) n_overrun = 1'b1;
                                n_rx_hold = n_rx_shift;
                                n_rx_full = 1'b1;
                            end
                            // Chain straight into the next byte if one waits.
                            if (r_tx_enable && !r_tx_empty) begin
                                n_tx_shift = r_tx_hold;
                                n_tx_empty = 1'b1;
                                n_tx_end   = 1'b0;
                                n_shifting = 1'b1;
                            end else begin
                                n_shifting = 1'b0;
                                n_tx_end   = 1'b1;
                            end
                        end else begin
                            n_bit_count = r_bit_count + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        o_result.busy_res = n_shifting;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_enable <= 1'b0;
            r_rx_enable <= 1'b0;
            r_tx_hold   <= 8'd0;
            r_tx_shift  <= SHIFT_IDLE;
            r_rx_shift  <= 8'd0;
            r_rx_hold   <= 8'd0;
            r_bit_count <= '0;
            r_tx_empty  <= 1'b1;
            r_rx_full   <= 1'b0;
            r_overrun   <= 1'b0;
            r_tx_end    <= 1'b1;
            r_shifting  <= 1'b0;
        end else begin
            r_tx_enable <= n_tx_enable;
            r_rx_enable <= n_rx_enable;
            r_tx_hold   <= n_tx_hold;
            r_tx_shift  <= n_tx_shift;
            r_rx_shift  <= n_rx_shift;
            r_rx_hold   <= n_rx_hold;
            r_bit_count <= n_bit_count;
            r_tx_empty  <= n_tx_empty;
            r_rx_full   <= n_rx_full;
            r_overrun   <= n_overrun;
            r_tx_end    <= n_tx_end;
            r_shifting  <= n_shifting;
        end
    end
endmodule

// ===== rtl/core/clocked_sync_serial_spi_master.sv =====
// ----------------------------------------------------------------------------
// Clocked synchronous serial master, top level
// A command item goes from the input register through the core to the output
// register. Throughput: one item per clock cycle while results are taken, set
// by the single update step in the core.
// Reset: synchronous and active low; both pipeline stages empty, registers and
// flags return to their power-on values and the bit order is LSB first.
// ----------------------------------------------------------------------------
module clocked_sync_serial_spi_master #(
    parameter int FRAME_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sspi_cmd_if.sink    i_cmd,
    sspi_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sspi_pkg::*;

    // The design is a two-register pipeline. The input register captures an
    // item from the command channel. Once the output register can take a result,
    // the core works out the item against its current state, updates that state
    // and hands the result to the output register, which decouples the result side,
    // so a command item can be taken while a finished result still waits.

    logic       r_in_valid;
    logic [1:0] r_func;
    logic [1:0] r_reg_sel;
    logic [7:0] r_wdata;
    logic       r_miso_bit;

    logic       r_out_valid;
    t_result    r_result;

    t_result    core_result;
    logic       msb_first;
    logic       advance;
    logic       step;
    logic       in_ready;

    // The output register can take a new result when it is empty or its
    // current one leaves this cycle. The input register frees up whenever
    // its item moves on to the core.
    assign advance  = !r_out_valid || o_res.ready;
    assign step     = r_in_valid && advance;
    assign in_ready = !r_in_valid || advance;

    assign i_cmd.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers carry no reset; they load only with a valid item.
    always_ff @(posedge i_clk) begin
        if (in_ready && i_cmd.valid) begin
            r_func     <= i_cmd.func;
            r_reg_sel  <= i_cmd.reg_sel;
            r_wdata    <= i_cmd.wdata;
            r_miso_bit <= i_cmd.miso_bit;
        end
        if (step) begin
            r_result <= core_result;
        end
    end

    // Configuration port for the bit order. A new setting applies from the
    // next serial bit onward.
    sspi_apb u_apb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_msb_first (msb_first)
    );

    // Register file, flags and shifters. The state changes only when an
    // item moves from the input register to the output register.
    sspi_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_func      (r_func),
        .i_reg_sel   (r_reg_sel),
        .i_wdata     (r_wdata),
        .i_miso_bit  (r_miso_bit),
        .i_msb_first (msb_first),
        .o_result    (core_result)
    );

    assign o_res.valid    = r_out_valid;
    assign o_res.rdata    = r_result.rdata;
    assign o_res.mosi_bit = r_result.mosi_bit;
    assign o_res.clocked  = r_result.clocked;
    assign o_res.busy_res = r_result.busy_res;
endmodule

// ===== tb/tb_clocked_sync_serial_spi_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the clocked synchronous serial master
// Drives bus reads, bus writes and serial bit ticks through the command
// channel. A cycle-free model of the registers, flags and shifters predicts
// every result item, which is checked field by field. The bit order is
// changed over the APB port between phases of different idling patterns.
// ----------------------------------------------------------------------------
module tb_clocked_sync_serial_spi_master;
    import sspi_pkg::*;

    localparam int FRAME_LEN        = 8;
    localparam int CLK_HALF         = 4;
    localparam int STALL_LIMIT      = 2000;
    localparam int ITEMS_PER_PHASE  = 200;
    localparam int NUM_PHASES       = 4;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES     = 8;

    // ------------------------------------------------------------------------
    // Behavioral model of the master plus the queue of predicted result items.
    // Every accepted command item produces exactly one result item.
    // ------------------------------------------------------------------------
    class serial_master_model;
        bit         msb_first;
        bit         tx_en;
        bit         rx_en;
        logic [7:0] tx_hold;
        logic [7:0] tx_shift;
        logic [7:0] rx_shift;
        logic [7:0] rx_hold;
        logic [3:0] bit_cnt;
        bit         tx_empty;
        bit         rx_full;
        bit         overrun;
        bit         tx_end;
        bit         busy;
        t_result    expected_results[$];
        int         mismatches;

        function new();
            msb_first  = 1'b0;
            tx_en      = 1'b0;
            rx_en      = 1'b0;
            tx_hold    = 8'h00;
            tx_shift   = SHIFT_IDLE;
            rx_shift   = 8'h00;
            rx_hold    = 8'h00;
            bit_cnt    = 4'd0;
            tx_empty   = 1'b1;
            rx_full    = 1'b0;
            overrun    = 1'b0;
            tx_end     = 1'b1;
            busy       = 1'b0;
            mismatches = 0;
        endfunction

        // A queued byte moves into the shifter whenever the transmitter is
        // enabled, idle, and the hold register has been marked as full.
        function void start_frame_if_ready();
            if (tx_en && !busy && !tx_empty) begin
                tx_shift = tx_hold;
                tx_empty = 1'b1;
                tx_end   = 1'b0;
                bit_cnt  = 4'd0;
                busy     = 1'b1;
            end
        endfunction

        function void take_cmd(input logic [1:0] func, input logic [1:0] sel,
                               input logic [7:0] wdata, input logic miso);
            t_result res;
            res.rdata    = 8'h00;
            res.mosi_bit = 1'b1;
            res.clocked  = 1'b0;
            if (func == FUNC_READ) begin
                case (sel)
                    REG_CTRL: begin
                        res.rdata[CTRL_TXE_BIT] = tx_en;
                        res.rdata[CTRL_RXE_BIT] = rx_en;
                    end
                    REG_TXDATA: res.rdata = tx_hold;
                    REG_STATUS: begin
                        res.rdata[STAT_TXEMPTY_BIT] = tx_empty;
                        res.rdata[STAT_RXFULL_BIT]  = rx_full;
                        res.rdata[STAT_OVERRUN_BIT] = overrun;
                        res.rdata[STAT_TXEND_BIT]   = tx_end;
                    end
                    default: res.rdata = rx_hold;
                endcase
            end else if (func == FUNC_WRITE) begin
                case (sel)
                    REG_CTRL: begin
                        tx_en = wdata[CTRL_TXE_BIT];
                        rx_en = wdata[CTRL_RXE_BIT];
                        // Turning the transmitter off aborts any frame.
                        if (!tx_en) begin
                            busy     = 1'b0;
                            bit_cnt  = 4'd0;
                            tx_shift = SHIFT_IDLE;
                            tx_empty = 1'b1;
                            tx_end   = 1'b1;
                        end
                    end
                    REG_TXDATA: tx_hold = wdata;
                    REG_STATUS: begin
                        // Flags clear on a written zero; transmit-end is read-only.
                        if (!wdata[STAT_TXEMPTY_BIT]) tx_empty = 1'b0;
                        if (!wdata[STAT_RXFULL_BIT])  rx_full  = 1'b0;
                        if (!wdata[STAT_OVERRUN_BIT]) overrun  = 1'b0;
                    end
                    default: ;
                endcase
                start_frame_if_ready();
            end else if (func == FUNC_TICK && busy) begin
                res.clocked = 1'b1;
                if (msb_first) begin
                    res.mosi_bit = tx_shift[7];
                    tx_shift     = {tx_shift[6:0], 1'b1};
                    if (rx_en) rx_shift = {rx_shift[6:0], miso};
                end else begin
                    res.mosi_bit = tx_shift[0];
                    tx_shift     = {1'b1, tx_shift[7:1]};
                    if (rx_en) rx_shift = {miso, rx_shift[7:1]};
                end
                if (bit_cnt >= 4'(FRAME_LEN - 1)) begin
                    bit_cnt = 4'd0;
                    if (rx_en) begin
                        if (rx_full) overrun = 1'b1;
                        rx_hold = rx_shift;
                        rx_full = 1'b1;
                    end
                    busy = 1'b0;
                    start_frame_if_ready();
                    if (!busy) tx_end = 1'b1;
                end else begin
                    bit_cnt = bit_cnt + 4'd1;
                end
            end
            res.busy_res = busy;
            expected_results.push_back(res);
        endfunction

        function void check_result(input t_result got);
            t_result exp;
            if (expected_results.size() == 0) begin
                $error("result item arrived with none expected");
                mismatches++;
                return;
            end
            exp = expected_results.pop_front();
            if (got.rdata !== exp.rdata) begin
                $error("rdata mismatch: expected %0h, got %0h", exp.rdata, got.rdata);
                mismatches++;
            end
            if (got.mosi_bit !== exp.mosi_bit) begin
                $error("mosi_bit mismatch: expected %0b, got %0b",
                       exp.mosi_bit, got.mosi_bit);
                mismatches++;
            end
            if (got.clocked !== exp.clocked) begin
                $error("clocked mismatch: expected %0b, got %0b", exp.clocked, got.clocked);
                mismatches++;
            end
            if (got.busy_res !== exp.busy_res) begin
                $error("busy_res mismatch: expected %0b, got %0b",
                       exp.busy_res, got.busy_res);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sspi_cmd_if cmd_ch ();
    sspi_res_if res_ch ();

    serial_master_model master_model;

    // Idling controls, changed by the main sequence between phases.
    int send_idle_pct;
    int rcv_stall_pct;
    int hold_off_left;
    int items_sent;
    int cfg_errors;
    int quiet_cycles;

    clocked_sync_serial_spi_master #(
        .FRAME_BITS(FRAME_LEN)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Offers one command item, with random idle cycles in front of it as the
    // current phase asks. Called at a falling edge and returns at one. Valid
    // stays high after acceptance so that back-to-back items need no gap.
    task automatic send_cmd(input logic [1:0] func, input logic [1:0] sel,
                            input logic [7:0] wdata, input logic miso);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid    = 1'b1;
        cmd_ch.func     = func;
        cmd_ch.reg_sel  = sel;
        cmd_ch.wdata    = wdata;
        cmd_ch.miso_bit = miso;
        do @(posedge i_clk); while (!cmd_ch.ready);
        master_model.take_cmd(func, sel, wdata, miso);
        items_sent++;
        @(negedge i_clk);
    endtask

    // One item of noise: any kind, any register, any data. Control writes
    // mostly keep the transmitter enabled so that frames are not aborted
    // too often.
    task automatic send_random_item();
        int         pick;
        logic [1:0] sel;
        logic [7:0] wd;
        pick = $urandom_range(99);
        sel  = 2'($urandom_range(3));
        wd   = 8'($urandom_range(255));
        if (pick < 45) begin
            send_cmd(FUNC_TICK, sel, wd, 1'($urandom_range(1)));
        end else if (pick < 70) begin
            if (sel == REG_CTRL && $urandom_range(9) != 0) wd[CTRL_TXE_BIT] = 1'b1;
            send_cmd(FUNC_WRITE, sel, wd, 1'($urandom_range(1)));
        end else if (pick < 95) begin
            send_cmd(FUNC_READ, sel, wd, 1'($urandom_range(1)));
        end else begin
            send_cmd(FUNC_UNUSED, sel, wd, 1'($urandom_range(1)));
        end
    endtask

    // A well-formed transfer: optionally set up control, load a byte, queue
    // it by clearing transmit-empty, tick through roughly a frame (sometimes
    // queueing a further byte mid-frame), then read back data and status.
    task automatic run_frame_sequence();
        logic [7:0] ctrl_val;
        logic [7:0] stat_val;
        int         n_ticks;
        if ($urandom_range(3) == 0) begin
            ctrl_val = 8'($urandom_range(255));
            ctrl_val[CTRL_TXE_BIT] = 1'b1;
            send_cmd(FUNC_WRITE, REG_CTRL, ctrl_val, 1'b0);
        end
        send_cmd(FUNC_WRITE, REG_TXDATA, 8'($urandom_range(255)), 1'b0);
        stat_val = 8'($urandom_range(255));
        stat_val[STAT_TXEMPTY_BIT] = 1'b0;
        send_cmd(FUNC_WRITE, REG_STATUS, stat_val, 1'b0);
        n_ticks = $urandom_range(20, 4);
        for (int i = 0; i < n_ticks; i++) begin
            if ($urandom_range(9) == 0)
                send_cmd(FUNC_WRITE, REG_STATUS, 8'($urandom_range(255)), 1'b0);
            else
                send_cmd(FUNC_TICK, 2'($urandom_range(3)), 8'($urandom_range(255)),
                         1'($urandom_range(1)));
        end
        send_cmd(FUNC_READ, REG_RXDATA, 8'h00, 1'b0);
        send_cmd(FUNC_READ, REG_STATUS, 8'h00, 1'b0);
    endtask

    // Writes the bit order register over APB and reads it back. Only called
    // while no command item is in flight, so the model can switch at once.
    task automatic write_bit_order(input logic msb);
        logic [31:0] readback;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {CFG_MSB_FIRST, 2'b00};
        pwdata  = {31'd0, msb};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        master_model.msb_first = msb;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback !== {31'd0, msb}) begin
            $error("msb_first readback mismatch: expected %0h, got %0h",
                   {31'd0, msb}, readback);
            cfg_errors++;
        end
    endtask

    // Lowers valid, then waits until every predicted result item has come back,
    // plus the drain time set by DRAIN_CYCLES so the two-stage pipeline is surely empty.
    task automatic drain_results();
        cmd_ch.valid = 1'b0;
        while (master_model.expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Receiver: ready is chosen at every falling edge. A requested hold-off
    // is counted down here, independent of the sender, so that the block
    // fills up and stalls its command input.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                res_ch.ready = 1'b0;
                hold_off_left--;
            end else begin
                res_ch.ready = ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // Result monitor: every accepted result item is checked against the
    // oldest prediction.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.rdata    = res_ch.rdata;
            got.mosi_bit = res_ch.mosi_bit;
            got.clocked  = res_ch.clocked;
            got.busy_res = res_ch.busy_res;
            master_model.check_result(got);
        end
    end

    // Watchdog: any accepted item on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int target;
        master_model    = new;
        send_idle_pct   = 0;
        rcv_stall_pct   = 0;
        hold_off_left   = 0;
        items_sent      = 0;
        cfg_errors      = 0;
        quiet_cycles    = 0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.func     = FUNC_READ;
        cmd_ch.reg_sel  = REG_CTRL;
        cmd_ch.wdata    = 8'h00;
        cmd_ch.miso_bit = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = 3'd0;
        pwdata          = 32'd0;
        i_rst_n         = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. Power-on values of all four registers, then an idle
        // tick, the unused item kind and an ignored write to receive data.
        send_cmd(FUNC_READ, REG_CTRL, 8'h00, 1'b0);
        send_cmd(FUNC_READ, REG_TXDATA, 8'h00, 1'b0);
        send_cmd(FUNC_READ, REG_STATUS, 8'h00, 1'b0);
        send_cmd(FUNC_READ, REG_RXDATA, 8'h00, 1'b0);
        send_cmd(FUNC_TICK, REG_CTRL, 8'h00, 1'b1);
        send_cmd(FUNC_UNUSED, REG_RXDATA, 8'hFF, 1'b1);
        send_cmd(FUNC_WRITE, REG_RXDATA, 8'hA5, 1'b1);
        // Enable both directions with all other bits set, send an all-zero
        // byte while sampling an alternating input pattern.
        send_cmd(FUNC_WRITE, REG_CTRL, 8'hFF, 1'b0);
        send_cmd(FUNC_WRITE, REG_TXDATA, 8'h00, 1'b0);
        send_cmd(FUNC_WRITE, REG_STATUS, 8'h7F, 1'b0);
        for (int i = 0; i < FRAME_LEN; i++)
            send_cmd(FUNC_TICK, REG_CTRL, 8'h00, 1'(i));
        send_cmd(FUNC_READ, REG_RXDATA, 8'h00, 1'b0);
        send_cmd(FUNC_READ, REG_STATUS, 8'h00, 1'b0);
        // All-ones byte with every status flag cleared, then an abort
        // mid-frame by a control write that keeps only receive enabled.
        send_cmd(FUNC_WRITE, REG_TXDATA, 8'hFF, 1'b0);
        send_cmd(FUNC_WRITE, REG_STATUS, 8'h00, 1'b0);
        send_cmd(FUNC_TICK, REG_CTRL, 8'h00, 1'b1);
        send_cmd(FUNC_TICK, REG_CTRL, 8'h00, 1'b0);
        send_cmd(FUNC_TICK, REG_CTRL, 8'h00, 1'b1);
        send_cmd(FUNC_WRITE, REG_CTRL, 8'h10, 1'b0);
        send_cmd(FUNC_READ, REG_STATUS, 8'h00, 1'b0);
        drain_results();

        // Random phases. The bit order alternates between them, and each
        // phase has its own idling pattern. The first one starts with a long
        // receiver hold-off while the sender keeps offering items.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            write_bit_order(1'(phase % 2 == 0));
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    rcv_stall_pct = 0;
                    hold_off_left = HOLD_OFF_CYCLES;
                end
                1: begin
                    send_idle_pct = 88;
                    rcv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    rcv_stall_pct = 88;
                end
                default: begin
                    send_idle_pct = 38;
                    rcv_stall_pct = 38;
                end
            endcase
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                if ($urandom_range(9) < 7)
                    run_frame_sequence();
                else
                    send_random_item();
            end
            drain_results();
        end

        // Leave the bit order back at its power-on value.
        write_bit_order(1'b0);
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        drain_results();

        if (master_model.expected_results.size() != 0) begin
            $error("%0d result items never arrived", master_model.expected_results.size());
            cfg_errors++;
        end
        if (master_model.mismatches == 0 && cfg_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== clocked_sync_serial_spi_master.f =====
rtl/core/sspi_pkg.sv
rtl/core/sspi_cmd_if.sv
rtl/core/sspi_res_if.sv
rtl/core/sspi_apb.sv
rtl/core/sspi_core.sv
rtl/core/clocked_sync_serial_spi_master.sv
tb/tb_clocked_sync_serial_spi_master.sv
